// File: sv/kbs_pkg.sv
// shared types, constants and lookup functions for the scancode to ascii fifo unit
`timescale 1ns / 1ps
`default_nettype none
package kbs_pkg;

    localparam int FIFO_DEPTH_DEF = 16;
    localparam int CHAR_W         = 7;
    localparam int CODE_W         = 8;
    localparam int CFG_W          = 7;

    localparam logic [CHAR_W-1:0] CH_LOWER_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 7'h7a;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'd32;
    localparam logic [CHAR_W-1:0] CH_NONE     = 7'h00;

    localparam logic [CFG_W-1:0] ECHO_ENABLE_RST = 7'd1;
    localparam logic [CFG_W-1:0] SHIFT_CODE_RST  = 7'd42;

    typedef enum logic
    {
        CFG_ECHO_ENABLE = 1'b0,
        CFG_SHIFT_CODE  = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        FUNC_SCAN = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    typedef struct packed
    {
        logic push;
        logic pop;
    } fifo_req_t;

    typedef struct packed
    {
        logic empty;
        logic full;
        logic empty_after;
    } fifo_status_t;

    // us layout, unshifted
    function automatic logic [CHAR_W-1:0] us_map(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c;
        begin
            case (code)
                7'd1:    c = 7'h1b;
                7'd2:    c = 7'h31;
                7'd3:    c = 7'h32;
                7'd4:    c = 7'h33;
                7'd5:    c = 7'h34;
                7'd6:    c = 7'h35;
                7'd7:    c = 7'h36;
                7'd8:    c = 7'h37;
                7'd9:    c = 7'h38;
                7'd10:   c = 7'h39;
                7'd11:   c = 7'h30;
                7'd12:   c = 7'h2d;
                7'd13:   c = 7'h3d;
                7'd14:   c = 7'h08;
                7'd15:   c = 7'h09;
                7'd16:   c = 7'h71;
                7'd17:   c = 7'h77;
                7'd18:   c = 7'h65;
                7'd19:   c = 7'h72;
                7'd20:   c = 7'h74;
                7'd21:   c = 7'h79;
                7'd22:   c = 7'h75;
                7'd23:   c = 7'h69;
                7'd24:   c = 7'h6f;
                7'd25:   c = 7'h70;
                7'd26:   c = 7'h5b;
                7'd27:   c = 7'h5d;
                7'd28:   c = 7'h0a;
                7'd30:   c = 7'h61;
                7'd31:   c = 7'h73;
                7'd32:   c = 7'h64;
                7'd33:   c = 7'h66;
                7'd34:   c = 7'h67;
                7'd35:   c = 7'h68;
                7'd36:   c = 7'h6a;
                7'd37:   c = 7'h6b;
                7'd38:   c = 7'h6c;
                7'd39:   c = 7'h3b;
                7'd40:   c = 7'h27;
                7'd41:   c = 7'h60;
                7'd43:   c = 7'h5c;
                7'd44:   c = 7'h7a;
                7'd45:   c = 7'h78;
                7'd46:   c = 7'h63;
                7'd47:   c = 7'h76;
                7'd48:   c = 7'h62;
                7'd49:   c = 7'h6e;
                7'd50:   c = 7'h6d;
                7'd51:   c = 7'h2c;
                7'd52:   c = 7'h2e;
                7'd53:   c = 7'h2f;
                7'd55:   c = 7'h2a;
                7'd57:   c = 7'h20;
                default: c = CH_NONE;
            endcase
            return c;
        end
    endfunction

    // us shift layer: upper case letters and punctuation
    function automatic logic [CHAR_W-1:0] apply_shift(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] s;
        begin
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            begin
                s = c - CASE_OFFSET;
            end
            else
            begin
                case (c)
                    7'h31:   s = 7'h21;
                    7'h32:   s = 7'h40;
                    7'h33:   s = 7'h23;
                    7'h34:   s = 7'h24;
                    7'h35:   s = 7'h25;
                    7'h36:   s = 7'h5e;
                    7'h37:   s = 7'h26;
                    7'h38:   s = 7'h2a;
                    7'h39:   s = 7'h28;
                    7'h30:   s = 7'h29;
                    7'h2d:   s = 7'h5f;
                    7'h3d:   s = 7'h2b;
                    7'h5b:   s = 7'h7b;
                    7'h5d:   s = 7'h7d;
                    7'h5c:   s = 7'h7c;
                    7'h3b:   s = 7'h3a;
                    7'h27:   s = 7'h22;
                    7'h2c:   s = 7'h3c;
                    7'h2e:   s = 7'h3e;
                    7'h2f:   s = 7'h3f;
                    7'h60:   s = 7'h7e;
                    default: s = c;
                endcase
            end
            return s;
        end
    endfunction

endpackage
`default_nettype wire

// File: sv/kbs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module kbs_ram
#(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: sv/kbs_xlate.sv
// scancode to ascii translation with shift layer
`timescale 1ns / 1ps
`default_nettype none
module kbs_xlate
(
    input  wire logic [kbs_pkg::CHAR_W-1:0] code,
    input  wire logic                       shift,
    output logic      [kbs_pkg::CHAR_W-1:0] ascii
);
    import kbs_pkg::*;

    logic [CHAR_W-1:0] base_char;

    assign base_char = us_map(code);
    assign ascii     = shift ? apply_shift(base_char) : base_char;

endmodule
`default_nettype wire

// File: sv/kbs_fifo.sv
// character ring fifo: pointers, count, storage and head prefetch
`timescale 1ns / 1ps
`default_nettype none
module kbs_fifo
#(
    parameter int FIFO_DEPTH = kbs_pkg::FIFO_DEPTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire kbs_pkg::fifo_req_t         req,
    input  wire logic [kbs_pkg::CHAR_W-1:0] push_char,
    output logic      [kbs_pkg::CHAR_W-1:0] head_char,
    output kbs_pkg::fifo_status_t           status
);
    import kbs_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              byp_valid_reg, byp_valid_next;
    logic [CHAR_W-1:0] byp_data_reg;
    logic [CHAR_W-1:0] ram_rd_data;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (req.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (req.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
        // ram reads the old word when written at the head address in the same cycle
        byp_valid_next = req.push && (wr_ptr_reg == rd_ptr_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            byp_data_reg <= push_char;
        end
    end

    kbs_ram
    #(
        .WIDTH (CHAR_W),
        .DEPTH (FIFO_DEPTH)
    )
    u_ram
    (
        .clk     (clk),
        .wr_en   (req.push),
        .wr_addr (wr_ptr_reg),
        .wr_data (push_char),
        .rd_addr (rd_ptr_next),
        .rd_data (ram_rd_data)
    );

    assign head_char          = byp_valid_reg ? byp_data_reg : ram_rd_data;
    assign status.empty       = (count_reg == '0);
    assign status.full        = (count_reg == CNT_FULL);
    assign status.empty_after = (count_next == '0);

endmodule
`default_nettype wire

// File: sv/keyboard_scancode_to_ascii_fifo_unit.sv
// top level: request register, translation, fifo and result register
//
// Each request is either a set-1 scancode event or a read of one character from
// the internal fifo. Requests are taken one per clock cycle while item_stall is
// low. A request sits in the request register, then translation and fifo update
// run in a single pass into the result register. The fifo head is prefetched
// from its ram every cycle, so a read takes its character from the prefetched head.
// The result register refills in the same cycle it is taken, so the input keeps
// flowing while results are drained. Pushes into a full fifo are dropped and
// flagged by overflow. Configuration writes take effect on the next cycle and
// should be made while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module keyboard_scancode_to_ascii_fifo_unit
#(
    parameter int FIFO_DEPTH = kbs_pkg::FIFO_DEPTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_index,
    input  wire logic [kbs_pkg::CFG_W-1:0]  cfg_data,

    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire logic                       func,
    input  wire logic [kbs_pkg::CODE_W-1:0] scan_code,

    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic                            char_made,
    output logic      [kbs_pkg::CHAR_W-1:0] new_char,
    output logic                            echo,
    output logic                            read_ok,
    output logic      [kbs_pkg::CHAR_W-1:0] read_char,
    output logic                            fifo_empty,
    output logic                            overflow
);
    import kbs_pkg::*;

    logic              echo_enable_reg;
    logic [CFG_W-1:0]  shift_code_reg;
    logic              shift_held_reg, shift_held_next;

    logic              s1_valid_reg, s1_valid_next;
    func_t             s1_func_reg;
    logic [CODE_W-1:0] s1_code_reg;

    logic              res_valid_reg, res_valid_next;
    logic              char_made_reg;
    logic [CHAR_W-1:0] new_char_reg;
    logic              echo_reg;
    logic              read_ok_reg;
    logic [CHAR_W-1:0] read_char_reg;
    logic              fifo_empty_reg;
    logic              overflow_reg;

    logic              accept;
    logic              s1_go;
    logic              is_read;
    logic              is_release;
    logic              is_shift_press;
    logic              is_char;
    logic              code_is_shift;
    logic [CHAR_W-1:0] xl_char;
    logic [CHAR_W-1:0] head_char;
    fifo_req_t         fifo_req;
    fifo_status_t      fifo_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_enable_reg <= ECHO_ENABLE_RST[0];
            shift_code_reg  <= SHIFT_CODE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ECHO_ENABLE: echo_enable_reg <= cfg_data[0];
                CFG_SHIFT_CODE:  shift_code_reg  <= cfg_data;
                default:         shift_code_reg  <= shift_code_reg;
            endcase
        end
    end

    // handshake
    assign s1_go      = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_go;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (s1_go)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // request decode
    assign is_read        = (s1_func_reg == FUNC_READ);
    assign code_is_shift  = (s1_code_reg[CHAR_W-1:0] == shift_code_reg);
    assign is_release     = !is_read && s1_code_reg[CODE_W-1];
    assign is_shift_press = !is_read && !s1_code_reg[CODE_W-1] && code_is_shift;
    assign is_char        = !is_read && !s1_code_reg[CODE_W-1] && !code_is_shift;

    always_comb
    begin
        shift_held_next = shift_held_reg;
        if (s1_go && is_release && code_is_shift)
        begin
            shift_held_next = 1'b0;
        end
        else if (s1_go && is_shift_press)
        begin
            shift_held_next = 1'b1;
        end
    end

    assign fifo_req.push = s1_go && is_char && !fifo_stat.full;
    assign fifo_req.pop  = s1_go && is_read && !fifo_stat.empty;

    kbs_xlate u_xlate
    (
        .code  (s1_code_reg[CHAR_W-1:0]),
        .shift (shift_held_reg),
        .ascii (xl_char)
    );

    kbs_fifo
    #(
        .FIFO_DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (fifo_req),
        .push_char (xl_char),
        .head_char (head_char),
        .status    (fifo_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            shift_held_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            res_valid_reg  <= res_valid_next;
            shift_held_reg <= shift_held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= func_t'(func);
            s1_code_reg <= scan_code;
        end
        if (s1_go)
        begin
            char_made_reg  <= is_char;
            new_char_reg   <= is_char ? xl_char : CH_NONE;
            echo_reg       <= is_char && echo_enable_reg;
            read_ok_reg    <= is_read && !fifo_stat.empty;
            read_char_reg  <= (is_read && !fifo_stat.empty) ? head_char : CH_NONE;
            fifo_empty_reg <= fifo_stat.empty_after;
            overflow_reg   <= is_char && fifo_stat.full;
        end
    end

    assign result_valid = res_valid_reg;
    assign char_made    = char_made_reg;
    assign new_char     = new_char_reg;
    assign echo         = echo_reg;
    assign read_ok      = read_ok_reg;
    assign read_char    = read_char_reg;
    assign fifo_empty   = fifo_empty_reg;
    assign overflow     = overflow_reg;

endmodule
`default_nettype wire
